// ===== rtl/fdbd_pkg.sv =====
// Shared constants, types and calendar helpers for the full-days-between-dates unit.
package fdbd_pkg;

  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned YearW   = 13;
  localparam int unsigned DaysW   = 12;
  // Year offset working width: year plus one walk step or up to seven search steps.
  localparam int unsigned YoffW   = 14;
  // Signed day accumulator width.
  localparam int unsigned AccW    = 14;
  localparam int unsigned MlenW   = 5;
  localparam int unsigned ProbeW  = 4;

  localparam logic [MonthW-1:0] MonJan  = 4'd0;
  localparam logic [MonthW-1:0] MonFeb  = 4'd1;
  localparam logic [MonthW-1:0] MonDec  = 4'd11;

  localparam logic [8:0]        DaysPerYear = 9'd365;
  localparam logic [DaysW-1:0]  MaxFullDays = 12'd4095;
  localparam logic [ProbeW-1:0] ProbeLast   = 4'd8;

  // Exact y / 100 for y < 43699: (y * 5243) >> 19.
  localparam int unsigned       DivShift   = 19;
  localparam int unsigned       ProdW      = 27;
  localparam int unsigned       QuotW      = 8;
  localparam logic [12:0]       DivHundMul = 13'd5243;

  typedef logic [MlenW-1:0] mlen_t;

  // Leap test request and response between sequencer and leap unit.
  typedef struct packed {
    logic             start;
    logic [YoffW-1:0] yoff;
  } leap_req_t;

  typedef struct packed {
    logic valid;
    logic leap;
  } leap_rsp_t;

  function automatic logic [MonthW-1:0] clamp_month(input logic [MonthW-1:0] m);
    return (m > MonDec) ? MonDec : m;
  endfunction

  function automatic mlen_t month_len(input logic [MonthW-1:0] m, input logic leap);
    mlen_t n;
    unique case (m)
      4'd0:    n = 5'd31;
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd30;
      4'd4:    n = 5'd31;
      4'd5:    n = 5'd30;
      4'd6:    n = 5'd31;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd30;
      4'd9:    n = 5'd31;
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/fdbd_leap.sv =====
// Two-step Gregorian leap-year tester on a year counted from 1900.
module fdbd_leap import fdbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  leap_req_t req_i,
  output leap_rsp_t rsp_o
);

  logic             vld_q;
  logic [YoffW-1:0] yoff_q;
  logic [QuotW-1:0] quot_q;
  logic [ProdW-1:0] prod;
  logic [YoffW-1:0] hund;
  logic             div100;

  // Quotient by 100 via reciprocal multiply.
  assign prod = ProdW'(req_i.yoff) * ProdW'(DivHundMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      yoff_q <= req_i.yoff;
      quot_q <= prod[DivShift +: QuotW];
    end
  end

  // quot * 100 as shift-add
  assign hund   = (YoffW'(quot_q) << 6) + (YoffW'(quot_q) << 5) + (YoffW'(quot_q) << 2);
  assign div100 = (hund == yoff_q);

  // 1900 is 0 mod 4 and mod 100, and 300 mod 400: centuries leap when quot mod 4 is 1.
  assign rsp_o.valid = vld_q;
  assign rsp_o.leap  = (yoff_q[1:0] == 2'b00) && (!div100 || (quot_q[1:0] == 2'b01));

endmodule

// ===== rtl/full_days_between_dates_unit.sv =====
// Top level: sequencer and shared accumulator for full days between two dates.
//
// Takes one pair of dates (month 0-11, day, year from 1900) per transfer and
// returns the count of whole days strictly between them. One item is worked
// at a time: in_ready_o is high only while the sequencer is idle. A single
// adder accumulates month lengths (or 365 per year in the leap-search case),
// and a shared two-step leap unit answers every February and search query.
// Equal dates go straight to the result; a same-month span checks the end
// day against the end month's length (a leap query when it is February);
// otherwise one month length is added per month walked (up to 12), with a
// leap query for each February; an end day beyond the end month's length
// adds 365 per year while searching for the next leap year, up to seven probes.
// The result sits in an output register,
// so the next item is taken while a finished result waits on out_ready_i;
// the sequencer only stalls when it finishes with that register still full.
// No reset-time sweep, no configuration.
module full_days_between_dates_unit import fdbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [DayW-1:0]   start_day_i,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [MonthW-1:0] end_month_i,
  input  logic [DayW-1:0]   end_day_i,
  input  logic [YearW-1:0]  end_year_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DaysW-1:0]  full_days_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MONTH = 5'b00010,   // month walk
    S_BCHK  = 5'b00100,   // same month: end day past month length?
    S_SRCH  = 5'b01000,   // search for next leap year
    S_DONE  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [MonthW-1:0]       mw_q, mw_d;     // walking month
  logic [MonthW-1:0]       m2_q, m2_d;     // end month
  logic [DayW-1:0]         d2_q, d2_d;
  logic [YoffW-1:0]        yw_q, yw_d;     // year under query
  logic [ProbeW-1:0]       probe_q, probe_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    out_vld_q, out_vld_d;
  logic [DaysW-1:0]        out_q, out_d;

  leap_req_t               lu_req;
  leap_rsp_t               lu_rsp;

  logic [MonthW-1:0]       m1c, m2c, mw_next, mlen_month;
  logic                    same_date, span_same;
  logic signed [AccW-1:0]  day_diff, addend, sum;
  logic                    need_leap, step_ok;
  mlen_t                   mlen;
  logic [DaysW-1:0]        clamped;

  fdbd_leap u_leap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lu_req),
    .rsp_o  (lu_rsp)
  );

  // Decode of the incoming pair
  assign m1c       = clamp_month(start_month_i);
  assign m2c       = clamp_month(end_month_i);
  assign same_date = (m1c == m2c) && (start_day_i == end_day_i) && (start_year_i == end_year_i);
  assign span_same = (m1c == m2c) && (start_day_i < end_day_i);
  assign day_diff  = AccW'(end_day_i) - AccW'(start_day_i) - AccW'(1);

  assign mw_next    = (mw_q == MonDec) ? MonJan : mw_q + 4'd1;
  assign mlen_month = (state_q == S_BCHK) ? m2_q : mw_q;
  assign mlen       = month_len(mlen_month, lu_rsp.leap);

  // Leap query: issue once, consume the cycle the answer shows up
  always_comb begin
    need_leap = 1'b0;
    unique case (state_q)
      S_MONTH: need_leap = (mw_q == MonFeb);
      S_BCHK:  need_leap = (m2_q == MonFeb);
      S_SRCH:  need_leap = 1'b1;
      default: need_leap = 1'b0;
    endcase
  end

  assign step_ok       = !need_leap || lu_rsp.valid;
  assign lu_req.start  = need_leap && !lu_rsp.valid;
  assign lu_req.yoff   = yw_q;

  // Shared adder
  assign addend = (state_q == S_MONTH) ? AccW'(mlen) : AccW'(DaysPerYear);
  assign sum    = acc_q + addend;

  // Final clamp to the output range
  always_comb begin
    if (acc_q < 0) begin
      clamped = '0;
    end else if (acc_q > $signed(AccW'(MaxFullDays))) begin
      clamped = MaxFullDays;
    end else begin
      clamped = acc_q[DaysW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    mw_d      = mw_q;
    m2_d      = m2_q;
    d2_d      = d2_q;
    yw_d      = yw_q;
    probe_d   = probe_q;
    acc_d     = acc_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    in_ready_o = 1'b0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mw_d    = m1c;
          m2_d    = m2c;
          d2_d    = end_day_i;
          probe_d = '0;
          acc_d   = same_date ? '0 : day_diff;
          if (same_date) begin
            state_d = S_DONE;
          end else if (span_same) begin
            yw_d    = YoffW'(end_year_i);
            state_d = S_BCHK;
          end else begin
            yw_d    = YoffW'(start_year_i);
            state_d = S_MONTH;
          end
        end
      end
      S_MONTH: begin
        if (step_ok) begin
          acc_d = sum;
          mw_d  = mw_next;
          if (mw_next == MonJan) begin
            yw_d = yw_q + YoffW'(1);
          end
          if (mw_next == m2_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_BCHK: begin
        if (step_ok) begin
          if (d2_q > mlen) begin
            acc_d   = sum;
            yw_d    = yw_q + YoffW'(1);
            probe_d = ProbeW'(1);
            state_d = S_SRCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SRCH: begin
        if (lu_rsp.valid) begin
          if (lu_rsp.leap) begin
            state_d = S_DONE;
          end else begin
            acc_d   = sum;
            yw_d    = yw_q + YoffW'(1);
            probe_d = probe_q + ProbeW'(1);
            if (probe_q + ProbeW'(1) == ProbeLast) begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = clamped;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mw_q    <= mw_d;
    m2_q    <= m2_d;
    d2_q    <= d2_d;
    yw_q    <= yw_d;
    probe_q <= probe_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign full_days_o = out_q;

endmodule

// ===== rtl/fdbd_checker.sv =====
// Port-level checker for the full-days-between-dates unit, bound to the top level.
module fdbd_checker import fdbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [MonthW-1:0] start_month_i,
  input logic [DayW-1:0]   start_day_i,
  input logic [YearW-1:0]  start_year_i,
  input logic [MonthW-1:0] end_month_i,
  input logic [DayW-1:0]   end_day_i,
  input logic [YearW-1:0]  end_year_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DaysW-1:0]  full_days_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(full_days_o))
    else $error("result changed while stalled");

  // One item at a time: busy right after an input transfer.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Equal dates give zero when the output register was free.
  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (start_month_i == end_month_i)
      && (start_day_i == end_day_i) && (start_year_i == end_year_i)
    |-> ##2 out_valid_o && (full_days_o == '0))
    else $error("equal dates did not give zero");

endmodule

bind full_days_between_dates_unit fdbd_checker u_fdbd_checker (.*);
